// ===== hdl/btcl_pkg.sv =====
`default_nettype none

package btcl_pkg;

  // Fixed field widths
  localparam int PTR_W      = 24;
  localparam int NODE_W     = 2 * PTR_W;
  localparam int LIMIT_W    = 19;
  localparam int TYPE_W     = 8;
  localparam int SLOT_W     = 18;
  localparam int ADDRESS_BITS = 32;
  localparam int ADDR_MSB   = ADDRESS_BITS - 1;
  localparam int STEP_W     = $clog2(ADDRESS_BITS + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PTR_W;

  // Pointer compare width: one bit over a pointer, so a node count of 2^24 fits
  localparam int CMP_W = PTR_W + 1;

  localparam int NODE_COUNT_DEF = 262144;

  // Reset values of the configuration registers
  localparam logic [PTR_W-1:0]   SEG_RESET   = 24'd16776960;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '0;
  localparam logic [TYPE_W-1:0]  TYPE_RESET  = 8'd255;

  // Edition byte of the country database
  localparam logic [TYPE_W-1:0] TYPE_COUNTRY = 8'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATABASE_TYPE = 2'd2;

  // Item commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes
  localparam logic STATUS_FOUND       = 1'b0;
  localparam logic STATUS_UNSUPPORTED = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [SLOT_W-1:0]       node_index;
    logic [PTR_W-1:0]        left_child;
    logic [PTR_W-1:0]        right_child;
    logic [ADDRESS_BITS-1:0] ip_address;
  } in_item_t;

  typedef struct packed {
    logic [PTR_W-1:0] country_index;
    logic             status;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // write the beat's node into the store
    logic start;       // begin a walk at node 0
    logic imm_result;  // lookup answered without a walk
    logic walking;     // walk in progress
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic imm_done;    // lookup needs no walk (wrong edition or empty trie)
    logic walk_done;   // current step ends the walk
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/btcl_stream_if.sv =====
`default_nettype none

interface btcl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/btcl_ctrl.sv =====
`default_nettype none

module btcl_ctrl
  import btcl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  input  wire logic item_cmd,
  output logic      item_ready,
  output logic      result_valid,
  input  wire logic result_ready,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   finish;

  // Take a beat when idle and the result slot is free or being drained
  assign item_ready = (state == ST_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;

  assign ctl.load       = accept && (item_cmd == CMD_LOAD);
  assign ctl.start      = accept && (item_cmd == CMD_LOOKUP) && !sts.imm_done;
  assign ctl.imm_result = accept && (item_cmd == CMD_LOOKUP) && sts.imm_done;
  assign ctl.walking    = (state == ST_WALK);

  assign finish = ctl.imm_result || (ctl.walking && sts.walk_done);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (ctl.start) state_next = ST_WALK;
      ST_WALK: if (sts.walk_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/btcl_dpath.sv =====
`default_nettype none

module btcl_dpath
  import btcl_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctl_t                  ctl,
  output sts_t                       sts,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_item_t              in_item,
  output out_item_t                  out_item
);

  localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam logic [CMP_W-1:0] NODE_END = CMP_W'(NODE_COUNT);

  // Configuration
  logic [PTR_W-1:0]   segment_base;
  logic [LIMIT_W-1:0] node_limit;
  logic [TYPE_W-1:0]  database_type;

  // Walk state
  logic [ADDRESS_BITS-1:0] addr_sh;
  logic [STEP_W-1:0]       steps_left;

  // Node store
  logic [NODE_W-1:0]  mem [NODE_COUNT];
  logic [NODE_W-1:0]  rdata;
  logic               wr_en;
  logic [CMP_W-1:0]   wr_slot;
  logic [NODE_AW-1:0] wr_addr;
  logic               rd_en;
  logic [NODE_AW-1:0] rd_addr;

  logic               unsupported;
  logic [PTR_W-1:0]   next_ptr;
  logic               leaf;
  logic               last_step;
  logic               beyond;
  logic               step;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_base  <= SEG_RESET;
      node_limit    <= LIMIT_RESET;
      database_type <= TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEGMENT_BASE:  segment_base  <= cfg_data;
        REG_NODE_LIMIT:    node_limit    <= cfg_data[LIMIT_W-1:0];
        REG_DATABASE_TYPE: database_type <= cfg_data[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Early answer: wrong edition, or no node below the limit
  assign unsupported  = (database_type != TYPE_COUNTRY);
  assign sts.imm_done = unsupported || (node_limit == '0);

  // One trie step per cycle on the registered node
  assign next_ptr  = addr_sh[ADDR_MSB] ? rdata[NODE_W-1:PTR_W] : rdata[PTR_W-1:0];
  assign leaf      = (next_ptr >= segment_base);
  assign last_step = (steps_left == STEP_W'(1));
  assign beyond    = (next_ptr >= {{(PTR_W-LIMIT_W){1'b0}}, node_limit})
                  || ({1'b0, next_ptr} >= NODE_END);
  assign sts.walk_done = leaf || last_step || beyond;
  assign step          = ctl.walking && !sts.walk_done;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      addr_sh    <= in_item.ip_address;
      steps_left <= STEP_W'(ADDRESS_BITS);
    end else if (step) begin
      addr_sh    <= addr_sh << 1;
      steps_left <= steps_left - STEP_W'(1);
    end
  end

  // Store ports: load writes, walk reads the root then each followed child
  assign wr_slot = {{(CMP_W-SLOT_W){1'b0}}, in_item.node_index};
  assign wr_en   = ctl.load && (wr_slot < NODE_END);
  assign wr_addr = wr_slot[NODE_AW-1:0];
  assign rd_en   = ctl.start || step;
  assign rd_addr = ctl.start ? '0 : next_ptr[NODE_AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_item.right_child, in_item.left_child};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.imm_result) begin
      out_item.country_index <= '0;
      out_item.status        <= unsupported ? STATUS_UNSUPPORTED : STATUS_FOUND;
    end else if (ctl.walking && sts.walk_done) begin
      out_item.country_index <= leaf ? (next_ptr - segment_base) : '0;
      out_item.status        <= STATUS_FOUND;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ipv4_binary_trie_country_lookup_unit.sv =====
// Loads: a load beat is written in the cycle it is taken and yields no result.
// A lookup result is valid in the cycle after the beat for a wrong edition or an
// empty trie, else after a walk over at most 32 trie levels. A new lookup waits for
// the previous walk to end, set by the chain of dependent node reads on the single
// read port of the node store; one load per cycle while idle, result slot free or draining.
// Reset clears the controller and the configuration registers; the node store keeps its contents.
`default_nettype none

module ipv4_binary_trie_country_lookup_unit
  import btcl_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  btcl_stream_if.sink                item,
  btcl_stream_if.source              result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_t      ctl;
  sts_t      sts;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item        = item.payload;
  assign result.payload = out_item;

  btcl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_cmd     (in_item.cmd),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .sts          (sts),
    .ctl          (ctl)
  );

  btcl_dpath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_item  (out_item)
  );

  // No node load while a walk reads the store
  assert property (@(posedge clk) disable iff (rst) ctl.walking |-> !ctl.load)
    else $error("node load during walk");

  // An early answer shows up in the next cycle with a zero index
  assert property (@(posedge clk) disable iff (rst)
    ctl.imm_result |=> result.valid && (result.payload.country_index == '0))
    else $error("early lookup answer missing");

  // A wrong edition never reports an index
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.payload.status == STATUS_UNSUPPORTED))
      |-> (result.payload.country_index == '0))
    else $error("unsupported result carries an index");

  // Nothing is taken while a walk is in flight
  assert property (@(posedge clk) disable iff (rst) ctl.walking |-> !item.ready)
    else $error("beat taken during walk");

endmodule

`default_nettype wire
